/* sv/dq_pkg.sv */
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types and constants of the double-ended queue: command and status
// codes, item structs and default sizing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dq_pkg;

    // default sizing
    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 8;

    // fixed field widths of the item ports
    localparam int VALUE_W  = 8;
    localparam int COUNT_W  = 5;

    // command codes
    typedef enum logic [2:0] {
        CMD_PUSH_BACK  = 3'd0,
        CMD_PUSH_FRONT = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_CLEAR      = 3'd4
    } t_cmd;

    // status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2
    } t_status;

    // input item
    typedef struct packed {
        t_cmd               cmd;
        logic [VALUE_W-1:0] value;
    } t_dq_in;

    // result item
    typedef struct packed {
        logic [VALUE_W-1:0] front_value;
        logic [VALUE_W-1:0] back_value;
        logic [COUNT_W-1:0] count;
        logic               is_empty;
        t_status            status;
    } t_dq_out;

endpackage

`default_nettype wire

/* sv/dq_ram.sv */
// ----------------------------------------------------------------------------
// dq_ram
// Generic RAM: one write port and two read ports, read data registered.
// A read of the address being written returns the old contents.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr_a,
    input  wire logic [AW-1:0]    i_raddr_b,
    output logic      [WIDTH-1:0] o_rdata_a,
    output logic      [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // registered read ports
    always_ff @(posedge i_clk) begin
        o_rdata_a <= mem[i_raddr_a];
        o_rdata_b <= mem[i_raddr_b];
    end

endmodule

`default_nettype wire

/* sv/double_ended_queue.sv */
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque held in a ring buffer RAM. Push/pop at either end or clear;
// every command returns front, back, count, empty flag and status.
// ----------------------------------------------------------------------------
//
//  channel   | ports                      | handshake
//  ----------+----------------------------+-----------------------------------
//  command   | start, busy, i_item        | taken when start & !busy
//  result    | o_valid, o_result          | one-cycle strobe, no back-pressure
//
//  Per command: the edge that takes it updates head/count, writes a pushed
//  value and issues the front/back RAM reads; the next edge registers the
//  result, shown for one cycle while the next command is taken. The RAM read
//  port is registered, hence the S_READ state; busy is high for 1 cycle.
//  A pushed value read back in the same cycle is forwarded around the RAM.
//  Reset (synchronous) empties the queue; RAM contents are not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue #(
    parameter int DEPTH      = dq_pkg::DEPTH,
    parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire dq_pkg::t_dq_in i_item,
    output logic                o_valid,
    output dq_pkg::t_dq_out     o_result
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;
    localparam int VW = dq_pkg::VALUE_W;
    localparam int OW = dq_pkg::COUNT_W;

    localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
    localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } t_state;

    t_state r_state, n_state;

    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;

    logic                  r_fwd_front, r_fwd_back;
    logic [DATA_WIDTH-1:0] r_wdata;
    dq_pkg::t_status       r_status, n_status;
    logic                  r_valid;
    dq_pkg::t_dq_out       r_result, n_result;

    logic                  accept;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic [AW-1:0]         front_addr, back_addr, tail_addr;
    logic [SW-1:0]         tail_sum, back_sum;
    logic [DATA_WIDTH-1:0] rd_front, rd_back;
    logic [DATA_WIDTH-1:0] front_d, back_d;
    logic [VW-1:0]         front_v, back_v;
    logic [OW-1:0]         count_v;

    assign accept = start && (r_state == S_IDLE);
    assign busy   = (r_state != S_IDLE);

    // input value to RAM width
    generate
        if (DATA_WIDTH <= VW) begin : g_win_trunc
            assign wr_data = i_item.value[DATA_WIDTH-1:0];
        end else begin : g_win_ext
            assign wr_data = {{(DATA_WIDTH - VW){1'b0}}, i_item.value};
        end
    endgenerate

    // slot just past the back element (count < DEPTH when used)
    assign tail_sum  = SW'(r_head) + SW'(r_count);
    assign tail_addr = (tail_sum >= DEPTH_S) ? AW'(tail_sum - DEPTH_S) : AW'(tail_sum);

    // command decode: pointer update, write and status
    always_comb begin
        n_head   = r_head;
        n_count  = r_count;
        n_status = dq_pkg::ST_OK;
        wr_en    = 1'b0;
        wr_addr  = tail_addr;
        case (i_item.cmd)
            dq_pkg::CMD_PUSH_BACK: begin
                if (r_count == DEPTH_C) begin
                    n_status = dq_pkg::ST_OVERFLOW;
                end else begin
                    wr_en   = accept;
                    n_count = r_count + 1'b1;
                end
            end
            dq_pkg::CMD_PUSH_FRONT: begin
                if (r_count == DEPTH_C) begin
                    n_status = dq_pkg::ST_OVERFLOW;
                end else begin
                    n_head  = (r_head == '0) ? LAST_A : r_head - 1'b1;
                    wr_en   = accept;
                    wr_addr = n_head;
                    n_count = r_count + 1'b1;
                end
            end
            dq_pkg::CMD_POP_FRONT: begin
                if (r_count == '0) begin
                    n_status = dq_pkg::ST_UNDERFLOW;
                end else begin
                    n_head  = (r_head == LAST_A) ? '0 : r_head + 1'b1;
                    n_count = r_count - 1'b1;
                end
            end
            dq_pkg::CMD_POP_BACK: begin
                if (r_count == '0) begin
                    n_status = dq_pkg::ST_UNDERFLOW;
                end else begin
                    n_count = r_count - 1'b1;
                end
            end
            dq_pkg::CMD_CLEAR: begin
                n_head  = '0;
                n_count = '0;
            end
            default: begin
            end
        endcase
    end

    // read addresses of the new front and back slots
    assign front_addr = n_head;
    assign back_sum   = SW'(n_head) + SW'(n_count) - 1'b1;
    assign back_addr  = (n_count == '0)       ? n_head :
                        (back_sum >= DEPTH_S) ? AW'(back_sum - DEPTH_S) : AW'(back_sum);

    dq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (wr_en),
        .i_waddr   (wr_addr),
        .i_wdata   (wr_data),
        .i_raddr_a (front_addr),
        .i_raddr_b (back_addr),
        .o_rdata_a (rd_front),
        .o_rdata_b (rd_back)
    );

    // forward a value written in the same cycle as its read
    assign front_d = r_fwd_front ? r_wdata : rd_front;
    assign back_d  = r_fwd_back  ? r_wdata : rd_back;

    generate
        if (DATA_WIDTH >= VW) begin : g_wout_trunc
            assign front_v = front_d[VW-1:0];
            assign back_v  = back_d[VW-1:0];
        end else begin : g_wout_ext
            assign front_v = {{(VW - DATA_WIDTH){1'b0}}, front_d};
            assign back_v  = {{(VW - DATA_WIDTH){1'b0}}, back_d};
        end
        if (CW >= OW) begin : g_cnt_trunc
            assign count_v = r_count[OW-1:0];
        end else begin : g_cnt_ext
            assign count_v = {{(OW - CW){1'b0}}, r_count};
        end
    endgenerate

    // result assembly; empty queue reads as zero
    always_comb begin
        n_result             = r_result;
        n_result.count       = count_v;
        n_result.is_empty    = (r_count == '0);
        n_result.status      = r_status;
        n_result.front_value = (r_count == '0) ? '0 : front_v;
        n_result.back_value  = (r_count == '0) ? '0 : back_v;
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (start) n_state = S_READ;
            S_READ:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == S_READ);
            if (accept) begin
                r_head  <= n_head;
                r_count <= n_count;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status    <= n_status;
            r_wdata     <= wr_data;
            r_fwd_front <= wr_en && (wr_addr == front_addr);
            r_fwd_back  <= wr_en && (wr_addr == back_addr);
        end
        if (r_state == S_READ) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

/* sv/dq_checker.sv */
// ----------------------------------------------------------------------------
// dq_checker
// Port-level checks of the double-ended queue, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dq_checker (
    input wire logic            i_clk,
    input wire logic            i_rst_n,
    input wire logic            start,
    input wire logic            busy,
    input wire logic            o_valid,
    input wire dq_pkg::t_dq_out o_result
);

    // every item taken is followed by its result strobe
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_valid)
        else $error("dq: item without result");

    // empty flag agrees with count
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.is_empty == (o_result.count == '0)))
        else $error("dq: empty flag and count disagree");

    // empty queue shows zero values
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.is_empty) |->
            (o_result.front_value == '0 && o_result.back_value == '0))
        else $error("dq: nonzero value on empty queue");

    // underflow only on an empty queue
    a_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.status == dq_pkg::ST_UNDERFLOW) |-> o_result.is_empty)
        else $error("dq: underflow with elements stored");

    // overflow only on a full queue
    a_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.status == dq_pkg::ST_OVERFLOW) |->
            (o_result.count == dq_pkg::COUNT_W'(dq_pkg::DEPTH)))
        else $error("dq: overflow below capacity");

endmodule

bind double_ended_queue dq_checker u_dq_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_valid  (o_valid),
    .o_result (o_result)
);

`default_nettype wire

/* tb/sv/tb_double_ended_queue.sv */
// ----------------------------------------------------------------------------
// tb_double_ended_queue
// Self-checking bench for the ring-buffer deque. Commands are sent in bursts
// with random gaps; a behavioral deque model predicts the front/back view,
// count, empty flag and status of every command, and each result strobe is
// compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_double_ended_queue;

    localparam int RANDOM_ITEMS   = 520;
    localparam int DRAIN_CYCLES   = 4;
    localparam int WATCHDOG_LIMIT = 400;

    logic            i_clk   = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            start   = 1'b0;
    dq_pkg::t_dq_in  i_item  = '0;
    logic            busy;
    logic            o_valid;
    dq_pkg::t_dq_out o_result;

    // behavioral deque state, empty after reset
    logic [dq_pkg::VALUE_W-1:0] ring_slots [dq_pkg::DEPTH];
    logic [3:0]                 ring_head = '0;
    logic [dq_pkg::COUNT_W-1:0] ring_fill = '0;

    dq_pkg::t_dq_out pending_views [$];
    int              n_errors    = 0;
    int              burst_left  = 0;
    int              idle_cycles = 0;

    double_ended_queue uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_valid (o_valid),
        .o_result(o_result)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // apply one command to the model and return the view it leaves
    function automatic dq_pkg::t_dq_out apply_deque_cmd(input dq_pkg::t_dq_in item);
        dq_pkg::t_dq_out view;
        dq_pkg::t_status st;
        logic [3:0]      pos;
        st = dq_pkg::ST_OK;
        case (item.cmd)
            dq_pkg::CMD_PUSH_BACK: begin
                if (ring_fill == dq_pkg::DEPTH) begin
                    st = dq_pkg::ST_OVERFLOW;
                end else begin
                    pos = ring_head + ring_fill[3:0];
                    ring_slots[pos] = item.value;
                    ring_fill++;
                end
            end
            dq_pkg::CMD_PUSH_FRONT: begin
                if (ring_fill == dq_pkg::DEPTH) begin
                    st = dq_pkg::ST_OVERFLOW;
                end else begin
                    ring_head = ring_head - 4'd1;
                    ring_slots[ring_head] = item.value;
                    ring_fill++;
                end
            end
            dq_pkg::CMD_POP_FRONT: begin
                if (ring_fill == 0) begin
                    st = dq_pkg::ST_UNDERFLOW;
                end else begin
                    ring_head = ring_head + 4'd1;
                    ring_fill--;
                end
            end
            dq_pkg::CMD_POP_BACK: begin
                if (ring_fill == 0) st = dq_pkg::ST_UNDERFLOW;
                else ring_fill--;
            end
            dq_pkg::CMD_CLEAR: begin
                ring_head = '0;
                ring_fill = '0;
            end
            default: ;  // unused codes leave the queue alone
        endcase

        view = '0;
        if (ring_fill != 0) begin
            pos = ring_head + ring_fill[3:0] - 4'd1;
            view.front_value = ring_slots[ring_head];
            view.back_value  = ring_slots[pos];
        end
        view.count    = ring_fill;
        view.is_empty = (ring_fill == 0);
        view.status   = st;
        return view;
    endfunction

    // present one item and hold it until taken; start is left high
    task automatic send_cmd(input dq_pkg::t_cmd c, input logic [dq_pkg::VALUE_W-1:0] v);
        dq_pkg::t_dq_in item;
        item.cmd   = c;
        item.value = v;
        start  <= 1'b1;
        i_item <= item;
        do @(posedge i_clk); while (busy);
        pending_views.push_back(apply_deque_cmd(item));
    endtask

    // burst bookkeeping: drop start for a random gap at the end of a burst
    task automatic pace_sender();
        int gap;
        if (burst_left != 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(1, 10);
            gap = $urandom_range(1, 8);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // hold off until every predicted view has been seen
    task automatic wait_for_views();
        start <= 1'b0;
        while (pending_views.size() != 0) @(posedge i_clk);
    endtask

    // empty queue: both pop kinds underflow, unused codes and clear are no-ops
    task automatic test_empty_queue();
        send_cmd(dq_pkg::CMD_POP_FRONT, 8'h00);
        pace_sender();
        send_cmd(dq_pkg::CMD_POP_BACK, 8'hFF);
        pace_sender();
        send_cmd(dq_pkg::t_cmd'(3'd5), 8'hFF);
        pace_sender();
        send_cmd(dq_pkg::t_cmd'(3'd6), 8'h00);
        pace_sender();
        send_cmd(dq_pkg::t_cmd'(3'd7), 8'hA5);
        pace_sender();
        send_cmd(dq_pkg::CMD_CLEAR, 8'h5A);
        wait_for_views();
    endtask

    // front push wraps the head below zero, fill to full, overflow both ends, pop and clear
    task automatic test_fill_and_wrap();
        int i;
        send_cmd(dq_pkg::CMD_PUSH_FRONT, 8'hFF);
        pace_sender();
        send_cmd(dq_pkg::CMD_PUSH_BACK, 8'h00);
        pace_sender();
        for (i = 0; i < dq_pkg::DEPTH - 2; i++) begin
            send_cmd((i % 2 == 0) ? dq_pkg::CMD_PUSH_FRONT : dq_pkg::CMD_PUSH_BACK,
                     dq_pkg::VALUE_W'(i * 37 + 3));
            pace_sender();
        end
        send_cmd(dq_pkg::CMD_PUSH_BACK, 8'h5A);
        pace_sender();
        send_cmd(dq_pkg::CMD_PUSH_FRONT, 8'hA5);
        pace_sender();
        send_cmd(dq_pkg::t_cmd'(3'd7), 8'h3C);
        pace_sender();
        send_cmd(dq_pkg::CMD_POP_BACK, 8'h00);
        pace_sender();
        send_cmd(dq_pkg::CMD_POP_FRONT, 8'h00);
        pace_sender();
        send_cmd(dq_pkg::CMD_POP_FRONT, 8'h00);
        pace_sender();
        send_cmd(dq_pkg::CMD_CLEAR, 8'h00);
        wait_for_views();
    endtask

    // random traffic drifting between fill-heavy and drain-heavy segments
    task automatic test_random_traffic();
        int           n;
        int           seg_left;
        int           push_pct;
        int           r;
        dq_pkg::t_cmd c;
        push_pct = 75;
        seg_left = $urandom_range(10, 60);
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (seg_left == 0) begin
                push_pct = (push_pct > 50) ? 25 : 75;
                seg_left = $urandom_range(10, 60);
            end
            seg_left--;
            r = $urandom_range(0, 99);
            if (r < 3)
                c = dq_pkg::CMD_CLEAR;
            else if (r < 6)
                c = dq_pkg::t_cmd'(3'($urandom_range(5, 7)));
            else if ($urandom_range(0, 99) < push_pct)
                c = ($urandom_range(0, 1) != 0) ? dq_pkg::CMD_PUSH_FRONT
                                                 : dq_pkg::CMD_PUSH_BACK;
            else
                c = ($urandom_range(0, 1) != 0) ? dq_pkg::CMD_POP_FRONT
                                                 : dq_pkg::CMD_POP_BACK;
            send_cmd(c, dq_pkg::VALUE_W'($urandom_range(0, 255)));
            if (n % 180 == 179) wait_for_views();
            else pace_sender();
        end
        wait_for_views();
    endtask

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            n_errors++;
        end
    endfunction

    // compare each result strobe with the oldest prediction
    always @(posedge i_clk) begin : check_views
        dq_pkg::t_dq_out want;
        if (i_rst_n && o_valid) begin
            if (pending_views.size() == 0) begin
                $error("result strobe with no command outstanding");
                n_errors++;
            end else begin
                want = pending_views.pop_front();
                check_field("front_value", want.front_value, o_result.front_value);
                check_field("back_value", want.back_value, o_result.back_value);
                check_field("count", want.count, o_result.count);
                check_field("is_empty", want.is_empty, o_result.is_empty);
                check_field("status", want.status, o_result.status);
            end
        end
    end

    // watchdog on cycles with no item taken and no result seen
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_queue();
        test_fill_and_wrap();
        test_random_traffic();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

/* files.f */
sv/dq_pkg.sv
sv/dq_ram.sv
sv/double_ended_queue.sv
sv/dq_checker.sv
tb/sv/tb_double_ended_queue.sv
